// ===== design/mm_pkg.sv =====
// Shared widths, limits and register indexes for the matrix multiplier.
`timescale 1ns / 1ps

package mm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int DIM_W     = 4;
	localparam int IDX_W     = 3;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int ADDR_W    = 6;
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

endpackage

// ===== design/mm_if.sv =====
// Valid/ready channel interfaces for input elements and product results.
`timescale 1ns / 1ps

interface mm_elem_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mm_pkg::DATA_W-1:0]     element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

interface mm_prod_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mm_pkg::DATA_W-1:0]     product;
	logic        [mm_pkg::IDX_W-1:0]      row;
	logic        [mm_pkg::IDX_W-1:0]      col;
	logic                                 last;
	logic                                 error;

	modport source (output valid, output product, output row, output col,
		output last, output error, input ready);
	modport sink (input valid, input product, input row, input col,
		input last, input error, output ready);
endinterface

// ===== design/matrix_multiply.sv =====
// Top level of the Q16.16 matrix multiplier.
`timescale 1ns / 1ps

// Elements of A and then B arrive row-major on element_ch, one item per cycle,
// and are written into two 64-entry memories with one write and one read port.
// After the last element of B the block computes C = A * B one element at a
// time: one multiply-accumulate per cycle through the memory read, the 32x32
// multiplier and the accumulator. Each product item starts in a wait state,
// held while the previous item waits to be taken, issues a_cols reads and then
// drains the pipeline; no new element is taken until the whole of C has
// been issued. Sums are exact, rounded half up to Q16.16 and saturated to 32
// bits. With a zero dimension, a dimension above eight or a_cols different from
// b_rows every element is dropped and answered by one item with error set. A
// configuration write resets the load position.

module matrix_multiply (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]          cfg_data,
	mm_elem_if.sink                           element_ch,
	mm_prod_if.source                         product_ch
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                        state_q;
	logic [mm_pkg::DIM_W-1:0]          a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [mm_pkg::CNT_W-1:0]          load_count_q;

	logic signed [mm_pkg::DATA_W-1:0]  a_store [mm_pkg::DEPTH];
	logic signed [mm_pkg::DATA_W-1:0]  b_store [mm_pkg::DEPTH];

	logic [mm_pkg::IDX_W-1:0]          i_q, j_q, k_q;
	logic [mm_pkg::ADDR_W-1:0]         a_base_q, b_addr_q;

	logic                              v_s1, first_s1, lastk_s1;
	logic signed [mm_pkg::DATA_W-1:0]  a_rd_s1, b_rd_s1;
	logic                              v_s2, first_s2, lastk_s2;
	logic signed [mm_pkg::PROD_W-1:0]  p_s2;
	logic                              done_s3;
	logic signed [mm_pkg::ACC_W-1:0]   acc_q;

	logic                              out_valid_q;
	logic signed [mm_pkg::DATA_W-1:0]  product_q;
	logic [mm_pkg::IDX_W-1:0]          row_q, col_q;
	logic                              last_q, error_q;

	logic                              dims_ok;
	logic [mm_pkg::CNT_W-1:0]          na, nb;
	logic [mm_pkg::CNT_W:0]            total, count_next;
	logic                              accept, take, out_free, load_err, load_res;
	logic                              in_a;
	logic [mm_pkg::ADDR_W-1:0]         wr_addr, a_rd_addr;
	logic                              i_last, j_last, k_last;
	logic signed [mm_pkg::ACC_W-1:0]   rnd;
	logic signed [mm_pkg::ACC_W-mm_pkg::FRAC_W-1:0] shifted;
	logic signed [mm_pkg::DATA_W-1:0]  sat;

	always_comb begin
		dims_ok = (a_rows_q != '0) && (a_cols_q != '0) && (b_rows_q != '0) &&
			(b_cols_q != '0) &&
			(a_rows_q <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) &&
			(a_cols_q <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) &&
			(b_rows_q <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) &&
			(b_cols_q <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) &&
			(a_cols_q == b_rows_q);
		na         = mm_pkg::CNT_W'(a_rows_q) * mm_pkg::CNT_W'(a_cols_q);
		nb         = mm_pkg::CNT_W'(b_rows_q) * mm_pkg::CNT_W'(b_cols_q);
		total      = {1'b0, na} + {1'b0, nb};
		count_next = {1'b0, load_count_q} + 1'b1;
		in_a       = (load_count_q < na);
		wr_addr    = in_a ? load_count_q[mm_pkg::ADDR_W-1:0]
			: mm_pkg::ADDR_W'(load_count_q - na);
		a_rd_addr  = a_base_q + mm_pkg::ADDR_W'(k_q);
		i_last     = ({1'b0, i_q} == a_rows_q - 1'b1);
		j_last     = ({1'b0, j_q} == b_cols_q - 1'b1);
		k_last     = ({1'b0, k_q} == a_cols_q - 1'b1);
	end

	assign take     = out_valid_q && product_ch.ready;
	assign out_free = !out_valid_q || take;
	assign element_ch.ready = (state_q == ST_LOAD) && (dims_ok || out_free);
	assign accept   = element_ch.valid && element_ch.ready;
	assign load_err = accept && !dims_ok;
	assign load_res = (state_q == ST_DRAIN) && done_s3;

	// Round half up at bit 15, then clamp to the signed 32-bit range.
	always_comb begin
		rnd     = acc_q + mm_pkg::ACC_W'(1 << (mm_pkg::FRAC_W - 1));
		shifted = rnd[mm_pkg::ACC_W-1:mm_pkg::FRAC_W];
		if (shifted[mm_pkg::ACC_W-mm_pkg::FRAC_W-1:mm_pkg::DATA_W-1] == '0 ||
			shifted[mm_pkg::ACC_W-mm_pkg::FRAC_W-1:mm_pkg::DATA_W-1] == '1) begin
			sat = shifted[mm_pkg::DATA_W-1:0];
		end else if (shifted[mm_pkg::ACC_W-mm_pkg::FRAC_W-1]) begin
			sat = {1'b1, {(mm_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(mm_pkg::DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && dims_ok && in_a) begin
			a_store[wr_addr] <= element_ch.element;
		end
		a_rd_s1 <= a_store[a_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && dims_ok && !in_a) begin
			b_store[wr_addr] <= element_ch.element;
		end
		b_rd_s1 <= b_store[b_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			a_rows_q     <= mm_pkg::DIM_W'(1);
			a_cols_q     <= mm_pkg::DIM_W'(1);
			b_rows_q     <= mm_pkg::DIM_W'(1);
			b_cols_q     <= mm_pkg::DIM_W'(1);
			load_count_q <= '0;
		end else if (cfg_we) begin
			load_count_q <= '0;
			case (cfg_index)
				mm_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mm_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mm_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mm_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!dims_ok) begin
							load_count_q <= '0;
						end else if (count_next >= total) begin
							load_count_q <= '0;
							state_q      <= ST_WAIT;
						end else begin
							load_count_q <= count_next[mm_pkg::CNT_W-1:0];
						end
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done_s3) begin
						state_q <= (i_last && j_last) ? ST_LOAD : ST_WAIT;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Loop indexes and running read addresses; A steps by one, B by a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			b_addr_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					i_q      <= '0;
					j_q      <= '0;
					a_base_q <= '0;
				end
				ST_WAIT: begin
					k_q      <= '0;
					b_addr_q <= mm_pkg::ADDR_W'(j_q);
				end
				ST_ISSUE: begin
					k_q      <= k_q + 1'b1;
					b_addr_q <= b_addr_q + mm_pkg::ADDR_W'(b_cols_q);
				end
				ST_DRAIN: begin
					if (done_s3) begin
						if (j_last) begin
							j_q      <= '0;
							i_q      <= i_q + 1'b1;
							a_base_q <= a_base_q + mm_pkg::ADDR_W'(a_cols_q);
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_ISSUE);
			v_s2    <= v_s1;
			done_s3 <= v_s2 && lastk_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		lastk_s1 <= k_last;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		p_s2     <= a_rd_s1 * b_rd_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? mm_pkg::ACC_W'(p_s2) : acc_q + mm_pkg::ACC_W'(p_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_err || load_res) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_err) begin
			product_q <= '0;
			row_q     <= '0;
			col_q     <= '0;
			last_q    <= 1'b0;
			error_q   <= 1'b1;
		end else if (load_res) begin
			product_q <= sat;
			row_q     <= i_q;
			col_q     <= j_q;
			last_q    <= i_last && j_last;
			error_q   <= 1'b0;
		end
	end

	assign product_ch.valid   = out_valid_q;
	assign product_ch.product = product_q;
	assign product_ch.row     = row_q;
	assign product_ch.col     = col_q;
	assign product_ch.last    = last_q;
	assign product_ch.error   = error_q;

endmodule

// ===== tb/matrix_multiply_tb.sv =====
// Self-checking testbench for the Q16.16 matrix multiplier: random traffic against a predictor.
`timescale 1ns / 1ps

module matrix_multiply_tb;

	localparam int STALL_LIMIT  = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS = 320;
	localparam int BIG_ROOM     = 160;
	localparam int OVERRUN      = 20;

	typedef struct packed {
		logic signed [mm_pkg::DATA_W-1:0] product;
		logic [mm_pkg::IDX_W-1:0]         row;
		logic [mm_pkg::IDX_W-1:0]         col;
		logic                             last;
		logic                             error;
	} c_elem_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [mm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mm_pkg::DIM_W-1:0]     cfg_data;

	mm_elem_if elem_if ();
	mm_prod_if prod_if ();

	matrix_multiply dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.element_ch (elem_if),
		.product_ch (prod_if)
	);

	logic signed [mm_pkg::DATA_W-1:0] elements_to_send[$];
	c_elem_t                          c_elements_due[$];
	int                               idle_rate;
	int                               mismatch_count;
	int                               send_gap;
	int                               ready_gap;
	int                               quiet_cycles;

	// Shadow copy of the multiplier's registers and stores.
	logic [mm_pkg::DIM_W-1:0]         mdl_a_rows, mdl_a_cols, mdl_b_rows, mdl_b_cols;
	logic signed [mm_pkg::DATA_W-1:0] mdl_a_mem [mm_pkg::DEPTH];
	logic signed [mm_pkg::DATA_W-1:0] mdl_b_mem [mm_pkg::DEPTH];
	int                               mdl_load_pos;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit dims_valid(logic [mm_pkg::DIM_W-1:0] ar,
		logic [mm_pkg::DIM_W-1:0] ac, logic [mm_pkg::DIM_W-1:0] br,
		logic [mm_pkg::DIM_W-1:0] bc);
		if (ar == 0 || ac == 0 || br == 0 || bc == 0)
			return 1'b0;
		if (ar > mm_pkg::MAX_DIM || ac > mm_pkg::MAX_DIM || br > mm_pkg::MAX_DIM ||
			bc > mm_pkg::MAX_DIM)
			return 1'b0;
		return ac == br;
	endfunction

	// Exact wide sum of Q32.32 products, rounded half up to Q16.16, then saturated.
	function automatic logic signed [mm_pkg::DATA_W-1:0] dot_q16(int i, int j);
		logic signed [71:0] acc;
		logic signed [71:0] rounded;
		longint             term;
		acc = '0;
		for (int k = 0; k < int'(mdl_a_cols); k++) begin
			term = longint'(mdl_a_mem[(i * mdl_a_cols + k) % mm_pkg::DEPTH]) *
				longint'(mdl_b_mem[(k * mdl_b_cols + j) % mm_pkg::DEPTH]);
			acc += 72'(term);
		end
		rounded = (acc + 72'sd32768) >>> mm_pkg::FRAC_W;
		if (rounded > 72'sd2147483647)
			return 32'sh7fffffff;
		if (rounded < -72'sd2147483648)
			return 32'sh80000000;
		return rounded[mm_pkg::DATA_W-1:0];
	endfunction

	function automatic void absorb_element(logic signed [mm_pkg::DATA_W-1:0] value);
		int      na;
		int      nb;
		c_elem_t c;
		if (!dims_valid(mdl_a_rows, mdl_a_cols, mdl_b_rows, mdl_b_cols)) begin
			c = '0;
			c.error = 1'b1;
			c_elements_due = {c_elements_due, c};
			mdl_load_pos = 0;
			return;
		end
		na = mdl_a_rows * mdl_a_cols;
		nb = mdl_b_rows * mdl_b_cols;
		if (mdl_load_pos < na)
			mdl_a_mem[mdl_load_pos] = value;
		else
			mdl_b_mem[mdl_load_pos - na] = value;
		mdl_load_pos++;
		if (mdl_load_pos < na + nb)
			return;
		mdl_load_pos = 0;
		for (int i = 0; i < int'(mdl_a_rows); i++) begin
			for (int j = 0; j < int'(mdl_b_cols); j++) begin
				c.product = dot_q16(i, j);
				c.row     = i[mm_pkg::IDX_W-1:0];
				c.col     = j[mm_pkg::IDX_W-1:0];
				c.last    = (i == mdl_a_rows - 1) && (j == mdl_b_cols - 1);
				c.error   = 1'b0;
				c_elements_due = {c_elements_due, c};
			end
		end
	endfunction

	function automatic logic signed [mm_pkg::DATA_W-1:0] random_element();
		logic [mm_pkg::DATA_W-1:0] x;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: x = $urandom;
			4, 5, 6, 7: x = $urandom_range(0, 32'h80000) - 32'h40000;
			8: begin
				case ($urandom_range(0, 5))
					0: x = 32'h7fffffff;
					1: x = 32'h80000000;
					2: x = 32'h00000000;
					3: x = 32'hffffffff;
					4: x = 32'h00010000;
					default: x = 32'hffff0000;
				endcase
			end
			default: x = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
		endcase
		return x;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Element driver: holds each item until it is taken, with random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_if.valid   <= 1'b0;
			elem_if.element <= '0;
			send_gap = 0;
		end else if (!elem_if.valid || elem_if.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				elem_if.valid <= 1'b0;
			end else if (elements_to_send.size() == 0) begin
				elem_if.valid <= 1'b0;
			end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
				send_gap = $urandom_range(1, 13) - 1;
				elem_if.valid <= 1'b0;
			end else begin
				elem_if.valid   <= 1'b1;
				elem_if.element <= elements_to_send.pop_front();
			end
		end
	end

	// Monitor: follows register writes and taken elements, checks every product item.
	always @(posedge clk or negedge arst_n) begin
		c_elem_t want;
		if (!arst_n) begin
			prod_if.ready <= 1'b0;
			ready_gap = 0;
			mdl_a_rows = 1;
			mdl_a_cols = 1;
			mdl_b_rows = 1;
			mdl_b_cols = 1;
			mdl_load_pos = 0;
			for (int n = 0; n < mm_pkg::DEPTH; n++) begin
				mdl_a_mem[n] = '0;
				mdl_b_mem[n] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mm_pkg::REG_A_ROWS: mdl_a_rows = cfg_data;
					mm_pkg::REG_A_COLS: mdl_a_cols = cfg_data;
					mm_pkg::REG_B_ROWS: mdl_b_rows = cfg_data;
					mm_pkg::REG_B_COLS: mdl_b_cols = cfg_data;
					default: ;
				endcase
				mdl_load_pos = 0;
			end
			if (elem_if.valid && elem_if.ready)
				absorb_element(elem_if.element);
			if (prod_if.valid && prod_if.ready) begin
				if (c_elements_due.size() == 0) begin
					report_mismatch($sformatf("unexpected item product %h row %0d col %0d",
						prod_if.product, prod_if.row, prod_if.col));
				end else begin
					want = c_elements_due.pop_front();
					if (prod_if.product !== want.product)
						report_mismatch($sformatf("C[%0d][%0d] product %h, want %h",
							want.row, want.col, prod_if.product, want.product));
					if (prod_if.row !== want.row)
						report_mismatch($sformatf("row %0d, want %0d", prod_if.row, want.row));
					if (prod_if.col !== want.col)
						report_mismatch($sformatf("col %0d, want %0d", prod_if.col, want.col));
					if (prod_if.last !== want.last)
						report_mismatch($sformatf("C[%0d][%0d] last %b, want %b",
							want.row, want.col, prod_if.last, want.last));
					if (prod_if.error !== want.error)
						report_mismatch($sformatf("error %b, want %b", prod_if.error, want.error));
				end
			end
			if (ready_gap > 0) begin
				ready_gap--;
				prod_if.ready <= 1'b0;
			end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
				ready_gap = $urandom_range(1, 13) - 1;
				prod_if.ready <= 1'b0;
			end else begin
				prod_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((elem_if.valid && elem_if.ready) || (prod_if.valid && prod_if.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("matrix_multiply_tb NOT OK");
				$finish;
			end
		end
	end

	// Returns once every element is taken and every product item has arrived,
	// then lets the block finish any store write still in flight.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (elements_to_send.size() != 0 || elem_if.valid || c_elements_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [mm_pkg::DIM_W-1:0] ar, logic [mm_pkg::DIM_W-1:0] ac,
		logic [mm_pkg::DIM_W-1:0] br, logic [mm_pkg::DIM_W-1:0] bc);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= mm_pkg::REG_A_ROWS;
		cfg_data  <= ar;
		@(posedge clk);
		cfg_index <= mm_pkg::REG_A_COLS;
		cfg_data  <= ac;
		@(posedge clk);
		cfg_index <= mm_pkg::REG_B_ROWS;
		cfg_data  <= br;
		@(posedge clk);
		cfg_index <= mm_pkg::REG_B_COLS;
		cfg_data  <= bc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_value(logic signed [mm_pkg::DATA_W-1:0] value);
		@(negedge clk);
		elements_to_send = {elements_to_send, value};
	endtask

	task automatic send_random(int count, ref int sent);
		@(negedge clk);
		repeat (count)
			elements_to_send = {elements_to_send, random_element()};
		sent += count;
	endtask

	initial begin : stimulus
		int                       sent;
		int                       pick;
		int                       run_len;
		logic [mm_pkg::DIM_W-1:0] ar, ac, br, bc;
		sent           = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		idle_rate      = 4;
		arst_n         = 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= mm_pkg::REG_A_ROWS;
		cfg_data        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape is 1x1 by 1x1: saturation both ways and the rounding ties.
		send_value(32'sh7fffffff);
		send_value(32'sh7fffffff);
		send_value(32'sh80000000);
		send_value(32'sh80000000);
		wait_idle();
		send_value(32'sh80000000);
		send_value(32'sh7fffffff);
		send_value(32'sh00008000);
		send_value(32'sh00000001);
		wait_idle();
		send_value(32'shffff8000);
		send_value(32'sh00000001);
		send_value(32'sh00010000);
		send_value(32'shffffffff);

		// A register write in the middle of a load starts the run over.
		write_dims(2, 2, 2, 2);
		send_random(3, sent);
		write_dims(2, 2, 2, 2);
		send_random(8, sent);

		// Bad shapes: a zero dimension, dimensions past the limit, inner mismatch.
		write_dims(0, 1, 1, 1);
		send_random(2, sent);
		write_dims(15, 15, 15, 15);
		send_value(32'sh7fffffff);
		write_dims(2, 3, 2, 2);
		send_random(2, sent);

		// Widest output and longest dot product.
		idle_rate = 3;
		write_dims(8, 1, 1, 8);
		send_random(16, sent);
		write_dims(1, 8, 8, 1);
		send_random(16, sent);

		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			// Large shapes only while there is room, so the run ends near its item count.
			if (pick < 4 && sent > RANDOM_ITEMS - BIG_ROOM)
				pick = 4;
			if (pick < 2) begin
				ar = $urandom_range(0, 15);
				ac = $urandom_range(0, 15);
				br = $urandom_range(0, 15);
				bc = $urandom_range(0, 15);
			end else if (pick < 4) begin
				ar = $urandom_range(1, 8);
				ac = $urandom_range(1, 8);
				br = ac;
				bc = $urandom_range(1, 8);
			end else begin
				ar = $urandom_range(1, 3);
				ac = $urandom_range(1, 3);
				br = ac;
				bc = $urandom_range(1, 3);
			end
			if (sent > RANDOM_ITEMS - 60)
				idle_rate = 0;
			else
				case ($urandom_range(0, 2))
					0: idle_rate = 0;
					1: idle_rate = 3;
					default: idle_rate = 10;
				endcase
			write_dims(ar, ac, br, bc);
			if (!dims_valid(ar, ac, br, bc)) begin
				send_random($urandom_range(1, 6), sent);
			end else begin
				run_len = ar * ac + br * bc;
				repeat ($urandom_range(1, 3)) begin
					if (sent + run_len <= RANDOM_ITEMS + OVERRUN) begin
						send_random(run_len, sent);
						if ($urandom_range(0, 5) == 0)
							wait_idle();
					end
				end
				// A partial run left behind is aborted by the next register write.
				if ($urandom_range(0, 5) == 0 && sent + run_len <= RANDOM_ITEMS + OVERRUN)
					send_random($urandom_range(1, run_len - 1), sent);
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("matrix_multiply_tb OK");
		else
			$display("matrix_multiply_tb NOT OK");
		$finish;
	end

endmodule
